// ===== sv/sgpm_pkg.sv =====
// Shared types and constants for the symbol grid prefix matcher.
// Used by the match cells, the best-hit tracker, the top level and the checker.
package sgpm_pkg;

   localparam int PATTERN_LEN     = 10;
   localparam int ROW_LEN_MAX     = 64;
   localparam int ROWS_MAX        = 64;

   localparam int SYM_W           = 2;
   localparam int LEN_W           = 4;
   localparam int COL_W           = 6;
   localparam int ROW_W           = 6;
   localparam int PATTERN_W       = 20;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 20;

   localparam logic [PATTERN_W-1:0] PATTERN_RESET   = PATTERN_W'(97749);
   localparam logic [LEN_W-1:0]     MIN_MATCH_RESET = LEN_W'(4);

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_MATCH = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [SYM_W-1:0] base;
      logic             row_end;
      logic             grid_end;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [ROW_W-1:0] hit_row;
      logic [COL_W-1:0] hit_column;
      logic [LEN_W-1:0] match_length;
   } rsp_type;

   // An open match attempt moving down the chain.
   typedef struct packed {
      logic             alive;
      logic [COL_W-1:0] start;
   } cand_type;

   // A finished attempt offered to the best-hit tracker.
   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] length;
      logic [COL_W-1:0] start;
   } offer_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
   } best_type;

endpackage

// ===== sv/sgpm_cell.sv =====
// One match cell: holds the attempt that has matched cell_len pattern symbols.
// Depends on sgpm_pkg.
module sgpm_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     flush,
   input  logic [sgpm_pkg::SYM_W-1:0] base,
   input  logic [sgpm_pkg::SYM_W-1:0] pat_sym,
   input  logic [sgpm_pkg::LEN_W-1:0] cell_len,
   input  sgpm_pkg::cand_type       left,
   output sgpm_pkg::cand_type       pass,
   output sgpm_pkg::offer_type      offer
);
   import sgpm_pkg::*;

   logic             alive_ff, alive_in;
   logic [COL_W-1:0] start_ff, start_in;
   logic             match;

   assign match = (pat_sym == base);

   // The attempt moves on only while it keeps matching and its row goes on.
   assign alive_in = accept ? (left.alive & ~flush) : alive_ff;
   assign start_in = accept ? left.start : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
      end else begin
         alive_ff <= alive_in;
      end
      start_ff <= start_in;
   end

   assign pass.alive = alive_ff & match;
   assign pass.start = start_ff;

   // A mismatch ends the attempt at its current length; a row end ends it
   // after this symbol has been counted.
   assign offer.valid  = alive_ff & (~match | flush);
   assign offer.length = match ? (cell_len + LEN_W'(1)) : cell_len;
   assign offer.start  = start_ff;

endmodule

// ===== sv/sgpm_best.sv =====
// Best-hit tracker: picks the strongest offer of a beat and keeps the best start.
// Depends on sgpm_pkg.
module sgpm_best (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       grid_end,
   input  logic [sgpm_pkg::ROW_W-1:0] row,
   input  sgpm_pkg::offer_type        offers [0:sgpm_pkg::PATTERN_LEN],
   output sgpm_pkg::best_type         best_next
);
   import sgpm_pkg::*;

   best_type  best_ff, best_in;
   offer_type win;
   logic      better;

   // A higher cell always carries a longer or equally long attempt that started
   // earlier in the row, so the highest valid offer wins within one beat.
   always_comb begin
      win = '0;
      for (int k = 0; k <= PATTERN_LEN; k++) begin
         if (offers[k].valid) begin
            win = offers[k];
         end
      end
   end

   always_comb begin
      better = 1'b0;
      if (win.valid) begin
         if (win.length > best_ff.length) begin
            better = 1'b1;
         end else if (win.length == best_ff.length) begin
            better = (row < best_ff.row) ||
                     ((row == best_ff.row) && (win.start < best_ff.column));
         end
      end
   end

   always_comb begin
      best_next = best_ff;
      if (better) begin
         best_next.length = win.length;
         best_next.row    = row;
         best_next.column = win.start;
      end
   end

   always_comb begin
      best_in = best_ff;
      if (accept) begin
         best_in = grid_end ? '0 : best_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

endmodule

// ===== sv/symbol_grid_prefix_match.sv =====
// Top level of the symbol grid prefix matcher: counters, chain of match cells,
// configuration registers and result register. Depends on sgpm_pkg, sgpm_cell, sgpm_best.
//
//   port group  | direction | handshake          | carries
//   req_        | in        | req_valid/req_stall | one grid symbol with row and grid end marks
//   rsp_        | out       | rsp_valid/rsp_stall | best match at grid end
//   csr_        | in        | csr_valid/csr_ready | pattern symbols, minimum match length
//
// One symbol is taken every cycle while req_stall is low; the chain of nine
// cells advances all open attempts in the same cycle, and the result of a grid
// is in the output register in the cycle after its last beat is taken.
// Reset is synchronous; it clears all attempts, counters and the best hit, and
// loads the register defaults.
// req_stall rises only while a result waits in the output register and rsp_stall is high.
module symbol_grid_prefix_match (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sgpm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sgpm_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sgpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sgpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sgpm_pkg::*;

   logic [PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [LEN_W-1:0]     min_match_ff, min_match_in;
   logic [COL_W-1:0]     column_ff, column_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 flush;
   logic                 csr_write;
   logic [LEN_W-1:0]     need;
   rsp_type              result;
   best_type             best_next;
   cand_type             pass_w  [0:PATTERN_LEN-1];
   offer_type            offer_w [0:PATTERN_LEN];

   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Row ends at its mark, at grid end, or at the last column a row can hold.
   assign flush = req_data.row_end | req_data.grid_end |
                  (column_ff == COL_W'(ROW_LEN_MAX - 1));

   // Configuration registers.
   always_comb begin
      pattern_in   = pattern_ff;
      min_match_in = min_match_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PATTERN:   pattern_in   = csr_data[PATTERN_W-1:0];
            CSR_MIN_MATCH: min_match_in = csr_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Position counters.
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (req_data.grid_end) begin
            column_in = '0;
            row_in    = '0;
         end else if (flush) begin
            column_in = '0;
            if (row_ff < ROW_W'(ROWS_MAX - 1)) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   // A new attempt opens at every column and is checked against the first
   // pattern symbol right away.
   assign pass_w[0].alive   = (pattern_ff[SYM_W-1:0] == req_data.base);
   assign pass_w[0].start   = column_ff;
   assign offer_w[0].valid  = pass_w[0].alive & flush;
   assign offer_w[0].length = LEN_W'(1);
   assign offer_w[0].start  = column_ff;

   for (genvar k = 1; k < PATTERN_LEN; k++) begin : g_cell
      sgpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .flush    (flush),
         .base     (req_data.base),
         .pat_sym  (pattern_ff[SYM_W*k +: SYM_W]),
         .cell_len (LEN_W'(k)),
         .left     (pass_w[k-1]),
         .pass     (pass_w[k]),
         .offer    (offer_w[k])
      );
   end

   // An attempt leaving the last cell has matched the whole pattern.
   assign offer_w[PATTERN_LEN].valid  = pass_w[PATTERN_LEN-1].alive;
   assign offer_w[PATTERN_LEN].length = LEN_W'(PATTERN_LEN);
   assign offer_w[PATTERN_LEN].start  = pass_w[PATTERN_LEN-1].start;

   sgpm_best u_best (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .grid_end  (req_data.grid_end),
      .row       (row_ff),
      .offers    (offer_w),
      .best_next (best_next)
   );

   // A minimum of zero behaves as one.
   assign need = (min_match_ff == '0) ? LEN_W'(1) : min_match_ff;

   always_comb begin
      result = '0;
      if (best_next.length >= need) begin
         result.found        = 1'b1;
         result.hit_row      = best_next.row;
         result.hit_column   = best_next.column;
         result.match_length = best_next.length;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept && req_data.grid_end) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= PATTERN_RESET;
         min_match_ff <= MIN_MATCH_RESET;
         column_ff    <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         min_match_ff <= min_match_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/sgpm_checker.sv =====
// Port-level checks for the symbol grid prefix matcher, bound to the top level.
// Depends on sgpm_pkg and symbol_grid_prefix_match.
module sgpm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input sgpm_pkg::req_type                req_data,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input sgpm_pkg::rsp_type                rsp_data,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [sgpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [sgpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sgpm_pkg::*;

   // A result beat appears only after the last beat of a grid was taken.
   a_rsp_after_grid_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_data.grid_end))
      else $error("result appeared without a grid end beat");

   // A held result holds back the input side.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while a result was stalled");

   // A not-found result carries all-zero fields.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         (rsp_data.hit_row == '0 && rsp_data.hit_column == '0 &&
          rsp_data.match_length == '0))
      else $error("not-found result with nonzero fields");

   // A found result has a length between one and the pattern length.
   a_found_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |->
         (rsp_data.match_length != '0 && rsp_data.match_length <= LEN_W'(PATTERN_LEN)))
      else $error("found result with impossible length");

   // A stalled result beat stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind symbol_grid_prefix_match sgpm_checker u_sgpm_checker (.*);

// ===== sim/symbol_grid_prefix_match_check.sv =====
`timescale 1ns / 1ps
// Checker for the symbol grid prefix matcher: watches the three channels,
// predicts the grid-end result from its own model of the match chain, and
// compares. Depends on sgpm_pkg.
module symbol_grid_prefix_match_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  sgpm_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  sgpm_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [sgpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sgpm_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatches,
   output int                               pending,
   output int                               results_checked,
   output int                               hits_found
);
   import sgpm_pkg::*;

   logic [PATTERN_W-1:0] pattern_reg;
   logic [LEN_W-1:0]     min_match_reg;

   logic [LEN_W-1:0]     try_len   [PATTERN_LEN];
   logic                 try_open  [PATTERN_LEN];
   logic [COL_W-1:0]     try_start [PATTERN_LEN];
   logic [COL_W-1:0]     column_pos;
   logic [ROW_W-1:0]     row_pos;
   best_type             best_hit;

   rsp_type              expected_hits [$];
   int                   fail_count = 0;
   int                   checked_count = 0;
   int                   hit_count = 0;

   assign mismatches      = fail_count;
   assign results_checked = checked_count;
   assign hits_found      = hit_count;

   function automatic logic [SYM_W-1:0] pattern_at(input int k);
      if (k >= PATTERN_LEN) return '0;
      return pattern_reg[SYM_W*k +: SYM_W];
   endfunction

   task automatic clear_grid();
      for (int i = 0; i < PATTERN_LEN; i++) begin
         try_len[i]   = '0;
         try_open[i]  = 1'b0;
         try_start[i] = '0;
      end
      column_pos = '0;
      row_pos    = '0;
      best_hit   = '0;
   endtask

   // Longest prefix wins; on equal length the earlier row, then column, wins.
   task automatic keep_if_better(input logic [LEN_W-1:0] len, input logic [COL_W-1:0] col);
      logic better;
      better = len > best_hit.length;
      if (len == best_hit.length &&
          (row_pos < best_hit.row || (row_pos == best_hit.row && col < best_hit.column)))
         better = 1'b1;
      if (better) begin
         best_hit.length = len;
         best_hit.row    = row_pos;
         best_hit.column = col;
      end
   endtask

   task automatic advance_grid(input req_type beat);
      int               slot;
      logic [LEN_W-1:0] need;
      rsp_type          hit;
      for (int i = 0; i < PATTERN_LEN; i++) begin
         if (try_open[i]) begin
            if (pattern_at(try_len[i]) == beat.base) begin
               try_len[i] = try_len[i] + 1'b1;
               if (try_len[i] >= PATTERN_LEN) begin
                  keep_if_better(try_len[i], try_start[i]);
                  try_open[i] = 1'b0;
               end
            end else begin
               keep_if_better(try_len[i], try_start[i]);
               try_open[i] = 1'b0;
            end
         end
      end

      slot = column_pos % PATTERN_LEN;
      try_start[slot] = column_pos;
      try_len[slot]   = '0;
      try_open[slot]  = 1'b0;
      if (pattern_at(0) == beat.base) begin
         try_len[slot]  = LEN_W'(1);
         try_open[slot] = 1'b1;
      end else begin
         keep_if_better('0, column_pos);
      end

      // The row closes on either mark, or by itself at the last column.
      if (beat.row_end || beat.grid_end || column_pos >= ROW_LEN_MAX - 1) begin
         for (int i = 0; i < PATTERN_LEN; i++) begin
            if (try_open[i]) begin
               keep_if_better(try_len[i], try_start[i]);
               try_open[i] = 1'b0;
            end
         end
         column_pos = '0;
         if (row_pos < ROWS_MAX - 1) row_pos = row_pos + 1'b1;
      end else begin
         column_pos = column_pos + 1'b1;
      end

      if (beat.grid_end) begin
         need = (min_match_reg == 0) ? LEN_W'(1) : min_match_reg;
         hit  = '0;
         if (best_hit.length >= need) begin
            hit.found        = 1'b1;
            hit.hit_row      = best_hit.row;
            hit.hit_column   = best_hit.column;
            hit.match_length = best_hit.length;
         end
         expected_hits.push_back(hit);
         clear_grid();
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pattern_reg   = PATTERN_RESET;
         min_match_reg = MIN_MATCH_RESET;
         clear_grid();
         expected_hits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               report_mismatch("result beat with nothing outstanding", 1, 0);
            end else begin
               want = expected_hits.pop_front();
               checked_count++;
               if (want.found) hit_count++;
               if (rsp_data.found !== want.found)
                  report_mismatch("found", rsp_data.found, want.found);
               if (rsp_data.hit_row !== want.hit_row)
                  report_mismatch("hit_row", rsp_data.hit_row, want.hit_row);
               if (rsp_data.hit_column !== want.hit_column)
                  report_mismatch("hit_column", rsp_data.hit_column, want.hit_column);
               if (rsp_data.match_length !== want.match_length)
                  report_mismatch("match_length", rsp_data.match_length, want.match_length);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PATTERN)
               pattern_reg = csr_data[PATTERN_W-1:0];
            else if (csr_index == CSR_MIN_MATCH)
               min_match_reg = csr_data[LEN_W-1:0];
         end
         if (req_valid && !req_stall)
            advance_grid(req_data);
      end
      pending <= expected_hits.size();
   end

endmodule

// ===== sim/symbol_grid_prefix_match_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the symbol grid prefix matcher: clock, reset, grid stimulus,
// register writes and the verdict. Depends on sgpm_pkg, the top level and the checker module.
module symbol_grid_prefix_match_test;
   import sgpm_pkg::*;

   typedef enum int {GRID_PLAIN, GRID_LONG_ROW, GRID_MANY_ROWS, GRID_NOISE} grid_shape_type;

   // Index with no register behind it; writes to it must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = CSR_INDEX_W'(3);

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatches;
   int pending;
   int results_checked;
   int hits_found;

   int send_idle = 0;
   int recv_idle = 0;
   int symbols_sent = 0;
   int grids_sent = 0;
   int phase_items = 0;
   int phase_grids = 0;
   logic [PATTERN_W-1:0] pattern_now = PATTERN_RESET;
   logic [LEN_W-1:0]     min_now;

   symbol_grid_prefix_match u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   symbol_grid_prefix_match_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked),
      .hits_found      (hits_found)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", pending);
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   function automatic req_type make_beat(input logic [SYM_W-1:0] base, input logic row_end,
                                         input logic grid_end);
      req_type beat;
      beat.base     = base;
      beat.row_end  = row_end;
      beat.grid_end = grid_end;
      return beat;
   endfunction

   function automatic logic [SYM_W-1:0] pattern_sym(input int k);
      return pattern_now[SYM_W*k +: SYM_W];
   endfunction

   task automatic send_symbol(input req_type beat);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      symbols_sent++;
      phase_items++;
   endtask

   task automatic plant_prefix(input int count);
      for (int k = 0; k < count; k++)
         send_symbol(make_beat(pattern_sym(k), 1'b0, 1'b0));
   endtask

   // Holds the sender until every predicted result has been taken.
   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Most rows carry a planted pattern prefix of random length at a random
   // column, so that long partial matches and ties happen often.
   task automatic send_grid(input grid_shape_type shape);
      int      rows;
      int      width;
      int      plant_at;
      int      plant_len;
      bit      planted;
      req_type beat;
      case (shape)
         GRID_LONG_ROW:  rows = 1;
         GRID_MANY_ROWS: rows = $urandom_range(68, 64);
         default:        rows = $urandom_range(3, 1);
      endcase
      for (int r = 0; r < rows; r++) begin
         case (shape)
            GRID_LONG_ROW:  width = $urandom_range(72, 64);
            GRID_MANY_ROWS: width = $urandom_range(2, 1);
            default:        width = $urandom_range(16, 1);
         endcase
         planted   = (shape != GRID_NOISE) && ($urandom_range(3) != 0);
         plant_len = $urandom_range(PATTERN_LEN, 1);
         plant_at  = $urandom_range(width - 1, 0);
         for (int c = 0; c < width; c++) begin
            if (planted && c >= plant_at && c < plant_at + plant_len)
               beat.base = pattern_sym(c - plant_at);
            else
               beat.base = $urandom_range(3);
            if (c == width - 1)
               beat.row_end = (r < rows - 1) ? 1'b1 : 1'($urandom_range(1));
            else
               beat.row_end = (shape == GRID_NOISE) && ($urandom_range(5) == 0);
            beat.grid_end = (r == rows - 1) && (c == width - 1);
            send_symbol(beat);
         end
      end
      grids_sent++;
      phase_grids++;
   endtask

   initial begin
      grid_shape_type shape;
      int             pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed grids under the reset register values.
      send_symbol(make_beat(2'd0, 1'b0, 1'b1));
      send_symbol(make_beat(2'd3, 1'b1, 1'b1));
      plant_prefix(PATTERN_LEN);
      send_symbol(make_beat(2'd3, 1'b0, 1'b1));
      // Same prefix at the start of two rows: the first row must be kept.
      plant_prefix(5);
      send_symbol(make_beat(2'd2, 1'b1, 1'b0));
      plant_prefix(5);
      send_symbol(make_beat(2'd2, 1'b0, 1'b1));
      grids_sent += 4;

      for (int setting = 0; setting < 6; setting++) begin
         wait_results();
         case (setting)
            0: begin pattern_now = 20'hFFFFF; min_now = 4'd10; end
            1: begin pattern_now = 20'h00000; min_now = 4'd1; end
            2: begin pattern_now = 20'($urandom); min_now = 4'd0; end
            3: begin pattern_now = 20'($urandom); min_now = 4'd15; end
            4: begin pattern_now = 20'($urandom); min_now = 4'($urandom_range(10, 1)); end
            default: begin pattern_now = 20'($urandom); min_now = MIN_MATCH_RESET; end
         endcase
         write_reg(CSR_PATTERN, pattern_now);
         write_reg(CSR_MIN_MATCH, CSR_DATA_W'(min_now));
         if (setting == 1) write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
         case (setting / 2)
            0: begin send_idle = 14; recv_idle = 84; end
            1: begin send_idle = 84; recv_idle = 14; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         phase_items = 0;
         phase_grids = 0;
         while (phase_items < 110 || phase_grids < 6) begin
            pick = $urandom_range(99);
            if (setting == 0 && phase_grids == 0)
               shape = GRID_LONG_ROW;
            else if (setting == 2 && phase_grids == 0)
               shape = GRID_MANY_ROWS;
            else if (pick < 3)
               shape = GRID_LONG_ROW;
            else if (pick < 4)
               shape = GRID_MANY_ROWS;
            else if (pick < 20)
               shape = GRID_NOISE;
            else
               shape = GRID_PLAIN;
            send_grid(shape);
            if (phase_grids == 3) wait_results();
         end
      end

      wait_results();
      repeat (10) @(posedge clock);
      $display("covered %0d symbols in %0d grids across six register settings",
               symbols_sent, grids_sent);
      $display("compared %0d results, %0d of them reporting a hit", results_checked, hits_found);
      if (mismatches == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
